/* design/fut_pkg.sv */
// ============================================================================
// fut_pkg: shared types and constants for the form body tokenizer
// Request and token structs, scanner codes, character constants and the
// hex digit decoder.
// ============================================================================
package fut_pkg;

	// Kind of one emitted token.
	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_PAIR_END = 2'd1,
		KIND_ERROR    = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	// Scanner mode.
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_HEX1    = 2'd1,
		MODE_HEX2    = 2'd2,
		MODE_DISCARD = 2'd3
	} scan_mode_t;

	// One raw byte request.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} byte_req_t;

	// One decoded token.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       in_value;
		logic       last_of_run;
	} token_t;

	// At most three tokens come from one request.
	localparam int MAX_RESULTS = 3;

	// Token queue sizing.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef logic [1:0] res_count_t;

	// Everything the scanner produces for one request.
	typedef struct packed {
		res_count_t                    count;
		token_t [MAX_RESULTS-1:0]      tokens;
	} scan_out_t;

	// Characters with a special meaning in the body.
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHAR_AMP     = 8'h26;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// Returns {ok, value}; ok is low for anything but 0-9, a-f and A-F.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
			[8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
			[8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
			default:       r = '0;
		endcase
		return r;
	endfunction

	// Builds a token; the byte and side are only carried by byte tokens.
	function automatic token_t make_token(input kind_t k, input logic [7:0] b,
			input logic v);
		token_t t;
		t.kind        = k;
		t.out_byte    = (k == KIND_BYTE) ? b : 8'h00;
		t.in_value    = (k == KIND_BYTE) ? v : 1'b0;
		t.last_of_run = 1'b0;
		return t;
	endfunction

endpackage

/* design/form_urlencoded_tokenizer.sv */
// ============================================================================
// form_urlencoded_tokenizer: streaming decoder for a form-encoded body
// Input register, single-pass scanner and a four-entry token queue.
// ============================================================================
// Takes one raw byte per clock and returns decoded tokens one per clock. A
// request is held in an input register, scanned in a single pass, and its
// tokens (none, one, or up to three on the final byte of a stream) are
// written into a four-entry queue whose head drives the token port; the
// tokens of a request pass through the input register and the queue before
// they reach the token port, and the move into the queue can stall.
// The input register moves on whenever the queue has room for three tokens,
// so ordinary bytes flow at one per clock. The single token port sets the
// sustained rate: a final byte that causes two or three tokens can hold the
// byte port, and back-pressure on the token port reaches the byte port once
// the queue holds more than one token.
module form_urlencoded_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  fut_pkg::byte_req_t byte_data,
	output logic               token_valid,
	input  logic               token_ready,
	output fut_pkg::token_t    token_data
);
	import fut_pkg::*;

	byte_req_t        item_s1;
	logic             valid_s1;
	logic             advance;
	logic             pop;
	logic [CNT_W-1:0] push_n;
	scan_out_t        scan;

	token_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;

	// The held request moves into the scanner when the queue has room for the
	// most tokens that one request can produce.
	assign advance    = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
	assign byte_ready = !valid_s1 || advance;
	assign pop        = token_valid && token_ready;
	assign push_n     = advance ? {1'b0, scan.count} : '0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_data;
		end
	end

	// Scanner.
	fut_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (item_s1),
		.result (scan)
	);

	// Token queue storage.
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (CNT_W'(k) < push_n) begin
				fifo_q[tail_q + PTR_W'(k)] <= scan.tokens[k];
			end
		end
	end

	// Token queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n[PTR_W-1:0];
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

	assign token_valid = (count_q != '0);
	assign token_data  = fifo_q[head_q];

endmodule

/* design/fut_scan.sv */
// ============================================================================
// fut_scan: byte scanner of the form body tokenizer
// Holds the scan mode, the name/value side and the pending high nibble, and
// turns one request into up to three tokens in a single pass.
// ============================================================================
module fut_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  fut_pkg::byte_req_t req,
	output fut_pkg::scan_out_t result
);
	import fut_pkg::*;

	scan_mode_t mode_q, mode_next, mode_mid;
	logic       value_side_q, value_side_next, value_side_mid;
	logic [3:0] high_nibble_q, high_nibble_next, high_nibble_mid;

	logic       main_vld, tail_vld, done_vld;
	token_t     main_tok, tail_tok;
	logic [4:0] hex;
	token_t     cand [MAX_RESULTS];
	logic       cand_vld [MAX_RESULTS];
	res_count_t n;

	// State registers, advanced once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NORMAL;
			value_side_q  <= 1'b0;
			high_nibble_q <= 4'h0;
		end else if (step) begin
			mode_q        <= mode_next;
			value_side_q  <= value_side_next;
			high_nibble_q <= high_nibble_next;
		end
	end

	// Next state and tokens for the current byte.
	always_comb begin
		hex             = hex_digit(req.in_byte);
		mode_mid        = mode_q;
		value_side_mid  = value_side_q;
		high_nibble_mid = high_nibble_q;
		main_vld        = 1'b0;
		main_tok        = make_token(KIND_BYTE, req.in_byte, value_side_q);
		tail_vld        = 1'b0;
		tail_tok        = make_token(KIND_ERROR, 8'h00, 1'b0);
		done_vld        = 1'b0;

		case (mode_q)
			MODE_NORMAL: begin
				if (req.in_byte == CHAR_PLUS) begin
					main_vld = 1'b1;
					main_tok = make_token(KIND_BYTE, CHAR_SPACE, value_side_q);
				end else if (req.in_byte == CHAR_PERCENT) begin
					mode_mid = MODE_HEX1;
				end else if (req.in_byte == CHAR_EQUALS) begin
					value_side_mid = 1'b1;
				end else if (req.in_byte == CHAR_AMP) begin
					main_vld       = 1'b1;
					main_tok       = make_token(KIND_PAIR_END, 8'h00, 1'b0);
					value_side_mid = 1'b0;
				end else begin
					main_vld = 1'b1;
				end
			end
			MODE_HEX1: begin
				if (hex[4]) begin
					high_nibble_mid = hex[3:0];
					mode_mid        = MODE_HEX2;
				end else begin
					main_vld = 1'b1;
					main_tok = make_token(KIND_ERROR, 8'h00, 1'b0);
					mode_mid = MODE_DISCARD;
				end
			end
			MODE_HEX2: begin
				main_vld = 1'b1;
				if (hex[4]) begin
					main_tok = make_token(KIND_BYTE, {high_nibble_q, hex[3:0]},
						value_side_q);
					mode_mid = MODE_NORMAL;
				end else begin
					main_tok = make_token(KIND_ERROR, 8'h00, 1'b0);
					mode_mid = MODE_DISCARD;
				end
			end
			default: begin
			end
		endcase

		// Stream end: flush a cut escape or an open value, then done.
		if (req.stream_end) begin
			if (mode_mid == MODE_HEX1 || mode_mid == MODE_HEX2) begin
				tail_vld = 1'b1;
			end else if (mode_mid == MODE_NORMAL && value_side_mid) begin
				tail_vld = 1'b1;
				tail_tok = make_token(KIND_PAIR_END, 8'h00, 1'b0);
			end
			done_vld         = 1'b1;
			mode_next        = MODE_NORMAL;
			value_side_next  = 1'b0;
			high_nibble_next = 4'h0;
		end else begin
			mode_next        = mode_mid;
			value_side_next  = value_side_mid;
			high_nibble_next = high_nibble_mid;
		end
	end

	// Pack the present tokens into the low slots and flag the last one.
	always_comb begin
		cand[0]     = main_tok;
		cand[1]     = tail_tok;
		cand[2]     = make_token(KIND_DONE, 8'h00, 1'b0);
		cand_vld[0] = main_vld;
		cand_vld[1] = tail_vld;
		cand_vld[2] = done_vld;
		result      = '0;
		n           = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (cand_vld[i]) begin
				result.tokens[n] = cand[i];
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			result.tokens[n - 2'd1].last_of_run = 1'b1;
		end
		result.count = n;
	end

endmodule

/* design/fut_checker.sv */
// ============================================================================
// fut_checker: port-level checks for the form body tokenizer
// Watches both ports for hold behavior and consistent token fields.
// ============================================================================
module fut_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input logic               byte_ready,
	input fut_pkg::byte_req_t byte_data,
	input logic               token_valid,
	input logic               token_ready,
	input fut_pkg::token_t    token_data
);
	import fut_pkg::*;

	// A stalled byte request stays presented and unchanged.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
		else $error("byte request changed or dropped while stalled");

	// A stalled token stays presented and unchanged.
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_data))
		else $error("token changed or dropped while stalled");

	// Only byte tokens carry a byte or a side.
	a_non_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_data.kind != KIND_BYTE |->
			token_data.out_byte == 8'h00 && !token_data.in_value)
		else $error("non-byte token carries payload");

	// Stream done is always the final token of its request.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_data.kind == KIND_DONE |-> token_data.last_of_run)
		else $error("stream done not marked last of run");

	// A token presented right after a taken stream done must be no stream done
	// or one marked as the last of its run.
	a_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_ready && token_data.kind == KIND_DONE ##1 token_valid
			|-> token_data.kind != KIND_DONE || token_data.last_of_run)
		else $error("token after stream done malformed");

endmodule

bind form_urlencoded_tokenizer fut_checker u_fut_checker (.*);
